/* rtl/core/kqf_pkg.sv */
// kqf_pkg: constants, types and the arctangent table for the keypoint quad block.
// No dependencies. Imported by every module in rtl/core.
package kqf_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int CORDIC_STEPS   = 14;
	localparam int ATAN_LEN       = 20;
	localparam int CORDIC_ITERS   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	localparam int CW             = COORD_WIDTH;
	localparam int SQW            = 2 * CW + 1;          // squared edge length
	localparam int RATIO_BITS     = 16;
	localparam int QWW            = SQW + RATIO_BITS;    // q * w2
	localparam int REMW           = SQW + RATIO_BITS + 1;
	localparam int DLW            = SQW + 2 * RATIO_BITS + 1;
	localparam int VW             = CW + 3;              // signed direction vector
	localparam int PRESCALE_SHIFT = 20;
	localparam int XW             = CW + 24;             // CORDIC x/y
	localparam int ZW             = 20;                  // angle, Q.16 radians, signed
	localparam int EW             = ZW + 2;              // angle error
	localparam int HALF_PI_Q16    = 102944;
	localparam int ERR_MAX        = 32767;

	// stage at which each path delivers, counting the input register as stage 1
	localparam int RATIO_END      = 2 + RATIO_BITS;
	localparam int ANGLE_END      = 4 + CORDIC_ITERS;
	localparam int LATENCY        = (RATIO_END > ANGLE_END) ? RATIO_END : ANGLE_END;
	localparam int RATIO_PAD      = LATENCY - RATIO_END;
	localparam int ANGLE_PAD      = LATENCY - ANGLE_END;

	localparam logic [3:0] POINTS_QUAD    = 4'd4;
	localparam logic [3:0] COLOUR_LAST    = 4'd3;
	localparam logic [2:0] COLOUR_UNKNOWN = 3'd4;
	localparam logic [3:0] NUM_HERO       = 4'd1;
	localparam logic [3:0] NUM_PLAIN_LAST = 4'd7;
	localparam logic [3:0] NUM_BASE_BIG   = 4'd8;
	localparam logic [3:0] PLATE_BASE     = 4'd7;
	localparam logic [3:0] PLATE_NONE     = 4'd8;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [ZW-1:0] ang_t;

	typedef struct packed {
		logic [15:0] centre_x;
		logic [15:0] centre_y;
		logic [2:0]  colour_class;
		logic [3:0]  plate_name;
		logic        is_big;
		logic        valid_res;
		logic        quad_ok;
	} side_t;

	function automatic ang_t atan_q16(input int i);
		ang_t r;
		case (i)
			0:  r = ZW'(51472);
			1:  r = ZW'(30385);
			2:  r = ZW'(16055);
			3:  r = ZW'(8150);
			4:  r = ZW'(4091);
			5:  r = ZW'(2047);
			6:  r = ZW'(1024);
			7:  r = ZW'(512);
			8:  r = ZW'(256);
			9:  r = ZW'(128);
			10: r = ZW'(64);
			11: r = ZW'(32);
			12: r = ZW'(16);
			13: r = ZW'(8);
			14: r = ZW'(4);
			15: r = ZW'(2);
			16: r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/kqf_front.sv */
// kqf_front: stage 1 (decode, centre, edge deltas, vectors) and stage 2 (squared lengths).
// Depends on kqf_pkg.
module kqf_front (
	input  logic                              clk,
	input  logic                              en,
	input  logic [3:0][15:0]                  pt_x,
	input  logic [3:0][15:0]                  pt_y,
	input  logic [3:0]                        point_count,
	input  logic [3:0]                        colour_code,
	input  logic [3:0]                        number_code,
	output kqf_pkg::side_t                    side_s1,
	output kqf_pkg::vec_t                     roll_x_s1,
	output kqf_pkg::vec_t                     roll_y_s1,
	output kqf_pkg::vec_t                     left_x_s1,
	output kqf_pkg::vec_t                     left_y_s1,
	output kqf_pkg::vec_t                     right_x_s1,
	output kqf_pkg::vec_t                     right_y_s1,
	output logic [kqf_pkg::SQW-1:0]           l2_s2,
	output logic [kqf_pkg::SQW-1:0]           w2_s2
);
	import kqf_pkg::*;

	logic [CW-1:0]   px [4];
	logic [CW-1:0]   py [4];
	logic [CW+1:0]   sum_x, sum_y;
	logic [CW-1:0]   adx_s1 [4];   // left, right, top, bottom
	logic [CW-1:0]   ady_s1 [4];
	logic [SQW-1:0]  sq [4];
	side_t           side;

	function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			px[k] = CW'(pt_x[k]);
			py[k] = CW'(pt_y[k]);
		end
		sum_x = (CW+2)'(px[0]) + (CW+2)'(px[1]) + (CW+2)'(px[2]) + (CW+2)'(px[3]);
		sum_y = (CW+2)'(py[0]) + (CW+2)'(py[1]) + (CW+2)'(py[2]) + (CW+2)'(py[3]);

		side.centre_x     = 16'(sum_x >> 2);
		side.centre_y     = 16'(sum_y >> 2);
		side.quad_ok      = (point_count == POINTS_QUAD);
		side.colour_class = (colour_code <= COLOUR_LAST) ? colour_code[2:0] : COLOUR_UNKNOWN;
		if (number_code <= NUM_PLAIN_LAST) begin
			side.plate_name = number_code;
		end else if (number_code == NUM_BASE_BIG) begin
			side.plate_name = PLATE_BASE;
		end else begin
			side.plate_name = PLATE_NONE;
		end
		side.is_big    = (number_code == NUM_HERO) || (number_code == NUM_BASE_BIG);
		side.valid_res = side.quad_ok && (number_code <= NUM_BASE_BIG);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1    <= side;
			adx_s1[0]  <= abs_diff(px[0], px[3]);
			ady_s1[0]  <= abs_diff(py[0], py[3]);
			adx_s1[1]  <= abs_diff(px[1], px[2]);
			ady_s1[1]  <= abs_diff(py[1], py[2]);
			adx_s1[2]  <= abs_diff(px[0], px[1]);
			ady_s1[2]  <= abs_diff(py[0], py[1]);
			adx_s1[3]  <= abs_diff(px[3], px[2]);
			ady_s1[3]  <= abs_diff(py[3], py[2]);
			// wrap-around subtraction gives the two's complement value directly
			roll_x_s1  <= $signed(VW'(px[1]) + VW'(px[2]) - VW'(px[0]) - VW'(px[3]));
			roll_y_s1  <= $signed(VW'(py[1]) + VW'(py[2]) - VW'(py[0]) - VW'(py[3]));
			left_x_s1  <= $signed(VW'(px[3]) - VW'(px[0]));
			left_y_s1  <= $signed(VW'(py[3]) - VW'(py[0]));
			right_x_s1 <= $signed(VW'(px[2]) - VW'(px[1]));
			right_y_s1 <= $signed(VW'(py[2]) - VW'(py[1]));
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sq[k] = SQW'(adx_s1[k]) * SQW'(adx_s1[k]) + SQW'(ady_s1[k]) * SQW'(ady_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w2_s2 <= (sq[1] > sq[0]) ? sq[1] : sq[0];
			l2_s2 <= (sq[3] > sq[2]) ? sq[3] : sq[2];
		end
	end

endmodule

/* rtl/core/kqf_ratio.sv */
// kqf_ratio: restoring square-root-of-quotient, one result bit per stage.
// Depends on kqf_pkg.
module kqf_ratio (
	input  logic                         clk,
	input  logic                         en,
	input  logic [kqf_pkg::SQW-1:0]      l2,
	input  logic [kqf_pkg::SQW-1:0]      w2,
	output logic [15:0]                  ratio
);
	import kqf_pkg::*;

	// invariant: rem = l2 * 2^16 - q^2 * w2, qw = q * w2
	logic [RATIO_BITS-1:0] q_s   [RATIO_BITS+1];
	logic [REMW-1:0]       rem_s [RATIO_BITS+1];
	logic [QWW-1:0]        qw_s  [RATIO_BITS+1];
	logic [SQW-1:0]        w2_s  [RATIO_BITS+1];
	logic                  wz_s  [RATIO_BITS+1];

	assign q_s[0]   = '0;
	assign rem_s[0] = REMW'(l2) << RATIO_BITS;
	assign qw_s[0]  = '0;
	assign w2_s[0]  = w2;
	assign wz_s[0]  = (w2 == '0);

	for (genvar k = 0; k < RATIO_BITS; k++) begin : g_bit
		localparam int B = RATIO_BITS - 1 - k;
		logic [DLW-1:0] delta;
		logic           take;

		assign delta = (DLW'(qw_s[k]) << (B + 1)) + (DLW'(w2_s[k]) << (2 * B));
		assign take  = (delta <= DLW'(rem_s[k]));

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= take ? (q_s[k] | (RATIO_BITS'(1) << B)) : q_s[k];
				rem_s[k+1] <= take ? REMW'(DLW'(rem_s[k]) - delta) : rem_s[k];
				qw_s[k+1]  <= take ? (qw_s[k] + (QWW'(w2_s[k]) << B)) : qw_s[k];
				w2_s[k+1]  <= w2_s[k];
				wz_s[k+1]  <= wz_s[k];
			end
		end
	end

	assign ratio = wz_s[RATIO_BITS] ? '0 : 16'(q_s[RATIO_BITS]);

endmodule

/* rtl/core/kqf_cordic.sv */
// kqf_cordic: pipelined vectoring CORDIC, atan2 in Q.16 radians, one rotation per stage.
// Depends on kqf_pkg.
module kqf_cordic (
	input  logic           clk,
	input  logic           en,
	input  kqf_pkg::vec_t  vx,
	input  kqf_pkg::vec_t  vy,
	output kqf_pkg::ang_t  angle
);
	import kqf_pkg::*;

	logic signed [XW-1:0] x_s [CORDIC_ITERS+1];
	logic signed [XW-1:0] y_s [CORDIC_ITERS+1];
	ang_t                 z_s [CORDIC_ITERS+1];
	logic                 zero_s [CORDIC_ITERS+1];
	logic signed [XW-1:0] x_in, y_in;

	assign x_in = XW'(vx) <<< PRESCALE_SHIFT;
	assign y_in = XW'(vy) <<< PRESCALE_SHIFT;

	// quadrant fold into the right half-plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vx == '0) && (vy == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= ZW'(HALF_PI_Q16);
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -ZW'(HALF_PI_Q16);
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_rot
		logic signed [XW-1:0] xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				if (y_s[k] > 0) begin
					x_s[k+1] <= x_s[k] + ys;
					y_s[k+1] <= y_s[k] - xs;
					z_s[k+1] <= z_s[k] + atan_q16(k);
				end else begin
					x_s[k+1] <= x_s[k] - ys;
					y_s[k+1] <= y_s[k] + xs;
					z_s[k+1] <= z_s[k] - atan_q16(k);
				end
			end
		end
	end

	assign angle = zero_s[CORDIC_ITERS] ? '0 : z_s[CORDIC_ITERS];

endmodule

/* rtl/core/kqf_err.sv */
// kqf_err: side angle error against roll, larger of the two, rounded to Q3.12.
// Depends on kqf_pkg.
module kqf_err (
	input  logic           clk,
	input  logic           en,
	input  kqf_pkg::ang_t  roll,
	input  kqf_pkg::ang_t  left_ang,
	input  kqf_pkg::ang_t  right_ang,
	output logic [14:0]    rect_error
);
	import kqf_pkg::*;

	logic signed [EW-1:0] el, er;
	logic [EW-1:0]        ml, mr;
	logic [EW-1:0]        max_s1;
	logic [EW:0]          rounded;

	assign el = EW'(left_ang)  - EW'(roll) - EW'(HALF_PI_Q16);
	assign er = EW'(right_ang) - EW'(roll) - EW'(HALF_PI_Q16);
	assign ml = (el < 0) ? EW'(-el) : EW'(el);
	assign mr = (er < 0) ? EW'(-er) : EW'(er);

	always_ff @(posedge clk) begin
		if (en) begin
			max_s1 <= (mr > ml) ? mr : ml;
		end
	end

	assign rounded = ((EW+1)'(max_s1) + (EW+1)'(8)) >> 4;

	always_ff @(posedge clk) begin
		if (en) begin
			rect_error <= (rounded > (EW+1)'(ERR_MAX)) ? 15'(ERR_MAX) : 15'(rounded);
		end
	end

endmodule

/* rtl/core/keypoint_quad_features_and_class.sv */
// keypoint_quad_features_and_class: quad geometry features and class decode per detection.
// Both result paths are balanced to kqf_pkg::LATENCY stages, set by the 16-stage ratio
// root and the CORDIC chain (fold + one stage per step + two error stages).
// Throughput one item per cycle; the whole pipe holds only while a result sits unread.
// Reset (arst_n low, asynchronous) clears the valid bits only; the datapath registers are not reset.
// Depends on kqf_pkg, kqf_front, kqf_ratio, kqf_cordic, kqf_err.
module keypoint_quad_features_and_class (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pt0_x,
	input  logic [15:0] pt0_y,
	input  logic [15:0] pt1_x,
	input  logic [15:0] pt1_y,
	input  logic [15:0] pt2_x,
	input  logic [15:0] pt2_y,
	input  logic [15:0] pt3_x,
	input  logic [15:0] pt3_y,
	input  logic [3:0]  point_count,
	input  logic [3:0]  colour_code,
	input  logic [3:0]  number_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] centre_x,
	output logic [15:0] centre_y,
	output logic [15:0] aspect_ratio,
	output logic [14:0] rect_error,
	output logic [2:0]  colour_class,
	output logic [3:0]  plate_name,
	output logic        is_big,
	output logic        valid_res
);
	import kqf_pkg::*;

	// one enable for every stage: the pipe moves unless the last stage holds an unread item
	logic en;
	logic valid_s [LATENCY+1];

	side_t            side_s [1:LATENCY];
	vec_t             roll_x_s1, roll_y_s1, left_x_s1, left_y_s1, right_x_s1, right_y_s1;
	logic [SQW-1:0]   l2_s2, w2_s2;
	ang_t             roll_ang, left_ang, right_ang;
	logic [15:0]      ratio_s [RATIO_PAD+1];
	logic [14:0]      err_s [ANGLE_PAD+1];
	side_t            side_out;

	assign en       = !(valid_s[LATENCY] && out_stall);
	assign in_stall = !en;

	assign valid_s[0] = in_valid;

	for (genvar k = 1; k <= LATENCY; k++) begin : g_valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// stages 1 and 2: decode, centre, deltas, squared lengths
	kqf_front u_front (
		.clk         (clk),
		.en          (en),
		.pt_x        ({pt3_x, pt2_x, pt1_x, pt0_x}),
		.pt_y        ({pt3_y, pt2_y, pt1_y, pt0_y}),
		.point_count (point_count),
		.colour_code (colour_code),
		.number_code (number_code),
		.side_s1     (side_s[1]),
		.roll_x_s1   (roll_x_s1),
		.roll_y_s1   (roll_y_s1),
		.left_x_s1   (left_x_s1),
		.left_y_s1   (left_y_s1),
		.right_x_s1  (right_x_s1),
		.right_y_s1  (right_y_s1),
		.l2_s2       (l2_s2),
		.w2_s2       (w2_s2)
	);

	// decoded fields and centre ride alongside the arithmetic
	for (genvar k = 2; k <= LATENCY; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// aspect ratio: one quotient bit a stage
	kqf_ratio u_ratio (
		.clk   (clk),
		.en    (en),
		.l2    (l2_s2),
		.w2    (w2_s2),
		.ratio (ratio_s[0])
	);

	// three atan2 units in step
	kqf_cordic u_cordic_roll (
		.clk   (clk),
		.en    (en),
		.vx    (roll_x_s1),
		.vy    (roll_y_s1),
		.angle (roll_ang)
	);

	kqf_cordic u_cordic_left (
		.clk   (clk),
		.en    (en),
		.vx    (left_x_s1),
		.vy    (left_y_s1),
		.angle (left_ang)
	);

	kqf_cordic u_cordic_right (
		.clk   (clk),
		.en    (en),
		.vx    (right_x_s1),
		.vy    (right_y_s1),
		.angle (right_ang)
	);

	kqf_err u_err (
		.clk        (clk),
		.en         (en),
		.roll       (roll_ang),
		.left_ang   (left_ang),
		.right_ang  (right_ang),
		.rect_error (err_s[0])
	);

	// balance the shorter path so both land on the last stage
	for (genvar k = 1; k <= RATIO_PAD; k++) begin : g_ratio_pad
		always_ff @(posedge clk) begin
			if (en) begin
				ratio_s[k] <= ratio_s[k-1];
			end
		end
	end

	for (genvar k = 1; k <= ANGLE_PAD; k++) begin : g_angle_pad
		always_ff @(posedge clk) begin
			if (en) begin
				err_s[k] <= err_s[k-1];
			end
		end
	end

	// a detection without four points reports all zero fields
	assign side_out     = side_s[LATENCY];
	assign out_valid    = valid_s[LATENCY];
	assign centre_x     = side_out.quad_ok ? side_out.centre_x : '0;
	assign centre_y     = side_out.quad_ok ? side_out.centre_y : '0;
	assign aspect_ratio = side_out.quad_ok ? ratio_s[RATIO_PAD] : '0;
	assign rect_error   = side_out.quad_ok ? err_s[ANGLE_PAD] : '0;
	assign colour_class = side_out.quad_ok ? side_out.colour_class : '0;
	assign plate_name   = side_out.quad_ok ? side_out.plate_name : '0;
	assign is_big       = side_out.quad_ok && side_out.is_big;
	assign valid_res    = side_out.valid_res;

endmodule

/* tb/sv/kqf_checker.sv */
`timescale 1ns / 1ps
// kqf_checker: watches both channels of the keypoint quad block, predicts each result
// from the accepted item and compares field by field. Depends on kqf_pkg.
module kqf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] pt0_x,
	input  logic [15:0] pt0_y,
	input  logic [15:0] pt1_x,
	input  logic [15:0] pt1_y,
	input  logic [15:0] pt2_x,
	input  logic [15:0] pt2_y,
	input  logic [15:0] pt3_x,
	input  logic [15:0] pt3_y,
	input  logic [3:0]  point_count,
	input  logic [3:0]  colour_code,
	input  logic [3:0]  number_code,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] centre_x,
	input  logic [15:0] centre_y,
	input  logic [15:0] aspect_ratio,
	input  logic [14:0] rect_error,
	input  logic [2:0]  colour_class,
	input  logic [3:0]  plate_name,
	input  logic        is_big,
	input  logic        valid_res,
	output int          n_errors,
	output int          n_pending
);
	import kqf_pkg::*;

	typedef struct packed {
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] ratio;
		logic [14:0] err;
		logic [2:0]  colour;
		logic [3:0]  plate;
		logic        big;
		logic        ok;
	} features_t;

	features_t expected_features[$];

	function automatic longint angle_q16(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		x = x * 1048576;
		y = y * 1048576;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI_Q16;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI_Q16;
			end
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += longint'(atan_q16(i));
			end else begin
				x -= ys; y += xs; z -= longint'(atan_q16(i));
			end
		end
		return z;
	endfunction

	function automatic longint sq_len(longint dx, longint dy);
		return dx * dx + dy * dy;
	endfunction

	function automatic features_t predict(logic [15:0] xs[4], logic [15:0] ys[4],
			logic [3:0] cnt, logic [3:0] col, logic [3:0] num);
		features_t f;
		longint px[4], py[4];
		longint w2, l2, roll, al, ar, el, er, t;
		logic [16:0] q, c;
		logic [127:0] lhs, rhs;
		f = '0;
		if (cnt != POINTS_QUAD)
			return f;
		for (int k = 0; k < 4; k++) begin
			px[k] = xs[k];
			py[k] = ys[k];
		end
		f.cx = 16'((px[0] + px[1] + px[2] + px[3]) >> 2);
		f.cy = 16'((py[0] + py[1] + py[2] + py[3]) >> 2);
		w2 = sq_len(px[0] - px[3], py[0] - py[3]);
		t = sq_len(px[1] - px[2], py[1] - py[2]);
		if (t > w2) w2 = t;
		l2 = sq_len(px[0] - px[1], py[0] - py[1]);
		t = sq_len(px[3] - px[2], py[3] - py[2]);
		if (t > l2) l2 = t;
		q = 0;
		if (w2 != 0)
			for (int b = 15; b >= 0; b--) begin
				c = q | (17'd1 << b);
				lhs = 128'(c) * 128'(c) * 128'(w2);
				rhs = 128'(l2) << 16;
				if (lhs <= rhs) q = c;
			end
		f.ratio = q[15:0];
		roll = angle_q16((py[1] + py[2]) - (py[0] + py[3]),
			(px[1] + px[2]) - (px[0] + px[3]));
		al = angle_q16(py[3] - py[0], px[3] - px[0]);
		ar = angle_q16(py[2] - py[1], px[2] - px[1]);
		el = al - roll - HALF_PI_Q16;
		er = ar - roll - HALF_PI_Q16;
		if (el < 0) el = -el;
		if (er < 0) er = -er;
		if (er > el) el = er;
		t = (el + 8) >> 4;
		f.err = (t > ERR_MAX) ? 15'(ERR_MAX) : 15'(t);
		f.colour = (col <= COLOUR_LAST) ? col[2:0] : COLOUR_UNKNOWN;
		if (num <= NUM_PLAIN_LAST) begin
			f.plate = num; f.ok = 1'b1;
		end else if (num == NUM_BASE_BIG) begin
			f.plate = PLATE_BASE; f.ok = 1'b1;
		end else begin
			f.plate = PLATE_NONE; f.ok = 1'b0;
		end
		f.big = (num == NUM_HERO || num == NUM_BASE_BIG);
		return f;
	endfunction

	assign n_pending = expected_features.size();

	always @(posedge clk or negedge arst_n) begin
		features_t want, got;
		logic [15:0] xs[4], ys[4];
		if (!arst_n) begin
			n_errors <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				xs = '{pt0_x, pt1_x, pt2_x, pt3_x};
				ys = '{pt0_y, pt1_y, pt2_y, pt3_y};
				expected_features.push_back(predict(xs, ys, point_count, colour_code,
					number_code));
			end
			if (out_valid && !out_stall) begin
				got = '{centre_x, centre_y, aspect_ratio, rect_error, colour_class,
					plate_name, is_big, valid_res};
				if (expected_features.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					n_errors <= n_errors + 1;
				end else begin
					want = expected_features.pop_front();
					if (want != got) begin
						$display("%0t: mismatch cx %h/%h cy %h/%h ratio %h/%h err %h/%h",
							$realtime, want.cx, got.cx, want.cy, got.cy, want.ratio,
							got.ratio, want.err, got.err);
						$display("%0t:   colour %h/%h plate %h/%h big %b/%b ok %b/%b",
							$realtime, want.colour, got.colour, want.plate, got.plate,
							want.big, got.big, want.ok, got.ok);
						n_errors <= n_errors + 1;
					end
				end
			end
		end
	end
endmodule

/* tb/sv/keypoint_quad_features_and_class_tb.sv */
`timescale 1ns / 1ps
// keypoint_quad_features_and_class_tb: stimulus and verdict for the keypoint quad block.
// Depends on kqf_pkg, the block and kqf_checker.
module keypoint_quad_features_and_class_tb;
	import kqf_pkg::*;

	localparam int N_RANDOM = 1950;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
	logic [15:0] pt0_x = '0, pt0_y = '0, pt1_x = '0, pt1_y = '0;
	logic [15:0] pt2_x = '0, pt2_y = '0, pt3_x = '0, pt3_y = '0;
	logic [3:0]  point_count = '0, colour_code = '0, number_code = '0;
	logic [15:0] centre_x, centre_y, aspect_ratio;
	logic [14:0] rect_error;
	logic [2:0]  colour_class;
	logic [3:0]  plate_name;
	logic        is_big, valid_res;
	int n_errors, n_pending;
	int idle_count = 0;
	bit hold_sink = 1'b0;   // long receiver hold-off requested by the stimulus

	always #2 clk = ~clk;

	keypoint_quad_features_and_class i_dut (.*);
	kqf_checker i_checker (.*);

	// watchdog: cycles with no item crossing either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stall per result, or a long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// offer one item and wait for it to be taken; idle cycles go first
	task automatic offer(logic [15:0] c[8], logic [3:0] cnt, logic [3:0] col,
			logic [3:0] num, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{pt0_x, pt0_y, pt1_x, pt1_y} <= {c[0], c[1], c[2], c[3]};
		{pt2_x, pt2_y, pt3_x, pt3_y} <= {c[4], c[5], c[6], c[7]};
		point_count <= cnt;
		colour_code <= col;
		number_code <= num;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// rectangle-ish quad around a random centre, with jitter on each corner; one draw in ten is four random corners
	function automatic void make_quad(output logic [15:0] c[8]);
		int cx, cy, hw, hh, j;
		int r = $urandom_range(0, 9);
		if (r == 0) begin
			for (int k = 0; k < 8; k++) c[k] = 16'($urandom);
			return;
		end
		hw = (r < 7) ? $urandom_range(0, 1200) : $urandom_range(0, 16000);
		hh = (r < 7) ? $urandom_range(0, 600) : $urandom_range(0, 16000);
		cx = $urandom_range(16384, 49151);
		cy = $urandom_range(16384, 49151);
		j = (r == 9) ? 4000 : 40;
		c[0] = 16'(cx - hw + $urandom_range(0, j)); c[1] = 16'(cy - hh + $urandom_range(0, j));
		c[2] = 16'(cx + hw + $urandom_range(0, j)); c[3] = 16'(cy - hh + $urandom_range(0, j));
		c[4] = 16'(cx + hw + $urandom_range(0, j)); c[5] = 16'(cy + hh + $urandom_range(0, j));
		c[6] = 16'(cx - hw + $urandom_range(0, j)); c[7] = 16'(cy + hh + $urandom_range(0, j));
	endfunction

	initial begin
		logic [15:0] c[8];
		logic [3:0] cnt;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero width, zero vectors, negative x axis, every code
		c = '{default: 16'h0};
		offer(c, POINTS_QUAD, 4'd0, 4'd0, 0);
		c = '{default: 16'hFFFF};
		offer(c, POINTS_QUAD, 4'd15, 4'd15, 0);
		c = '{16'h0, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF};
		offer(c, POINTS_QUAD, 4'd1, 4'd1, 0);
		// mirrored quad: roll on the negative x axis
		c = '{16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		offer(c, POINTS_QUAD, 4'd2, 4'd8, 0);
		// zero width, large length: ratio 0
		c = '{16'h0, 16'h100, 16'hFFFF, 16'h100, 16'hFFFF, 16'h100, 16'h0, 16'h100};
		offer(c, POINTS_QUAD, 4'd3, 4'd9, 0);
		// tiny width, huge length: saturating ratio
		c = '{16'h0, 16'h100, 16'hFFFF, 16'h100, 16'hFFFF, 16'h101, 16'h0, 16'h101};
		offer(c, POINTS_QUAD, 4'd4, 4'd7, 0);
		for (int k = 0; k < 16; k++) begin
			make_quad(c);
			offer(c, (k % 3 == 2) ? 4'(k) : POINTS_QUAD, 4'(k), 4'(k), 0);
		end

		// random: mostly valid quads, some noise
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 600) hold_sink = 1'b1;
			if (n == 1200) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (n_pending != 0) @(posedge clk);
			end
			make_quad(c);
			cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom) : POINTS_QUAD;
			offer(c, cnt, 4'($urandom_range(0, 5)), 4'($urandom),
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
			if ((n / 150) % 4 == 3) hold_sink = hold_sink;
		end
		in_valid <= 1'b0;

		while (n_pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/kqf_pkg.sv
rtl/core/kqf_front.sv
rtl/core/kqf_ratio.sv
rtl/core/kqf_cordic.sv
rtl/core/kqf_err.sv
rtl/core/keypoint_quad_features_and_class.sv
tb/sv/kqf_checker.sv
tb/sv/keypoint_quad_features_and_class_tb.sv
